FILE: src/contiguous_page_slot_mapper_macros.svh
// ----------------------------------------------------------------------------
// contiguous_page_slot_mapper_macros.svh
// Assertion macros for the page slot mapper core.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_SLOT_MAPPER_MACROS_SVH
`define CONTIGUOUS_PAGE_SLOT_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CPSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CPSM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsm: next-cycle check failed");

`endif

FILE: src/cpsm_pkg.sv
// ----------------------------------------------------------------------------
// cpsm_pkg
// Types, codes and constants of the contiguous page slot mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsm_pkg;

    localparam int SLOT_W     = 9;
    localparam int RUN_W      = 10;
    localparam int WALK_W     = 11;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 64;
    localparam int PHYS_W     = 52;
    localparam int SIZE_W     = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_SLOTS = 511;
    localparam logic [ADDR_W-1:0] DEF_WINDOW_BASE = 64'hFFFF_FFFF_FFE0_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_ZERO_ARG  = 3'd1,
        STS_TOO_LARGE = 3'd2,
        STS_NO_ROOM   = 3'd3,
        STS_BAD_SLOT  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DYNAMIC_SLOT  = 2'd0,
        CFG_WINDOW_BASE_ADDRESS = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FILL,
        ST_UNMAP,
        ST_ERASE,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PHYS_W-1:0] physical_address;
        logic [SIZE_W-1:0] map_size;
        logic [ADDR_W-1:0] entry_flags;
        logic [ADDR_W-1:0] virtual_address;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_value;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   mapped_address;
        logic [SLOT_W-1:0]   first_slot;
        logic [SLOT_W-1:0]   slot_count;
        logic [ADDR_W-1:0]   read_value;
    } out_beat_t;

endpackage

`default_nettype wire

FILE: src/cpsm_ram.sv
// ----------------------------------------------------------------------------
// cpsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/contiguous_page_slot_mapper.sv
// ----------------------------------------------------------------------------
// contiguous_page_slot_mapper
// First-fit contiguous allocator over a window of page-table slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+---------------------------
//  in      | into      | in_valid / in_stall  | in_beat_t  (one command)
//  out     | out of    | out_valid / out_stall| out_beat_t (one result)
//  cfg     | into      | cfg_valid / cfg_ready| cfg_index + cfg_data
//
//  Map walks the run-length table, then fills the page entries, one RAM
//  access per walk step or page; unmap reads the run and erases its n slots;
//  a read fetches its entry; a write or a command refused on arrival goes
//  straight to the result state. Reset: both RAMs are swept to zero with
//  in_stall high; config writes are taken throughout. Stalls: a result waits
//  in the output register while the next command runs; the core holds in its
//  result state only while that register is full and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_slot_mapper
    import cpsm_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_beat_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_beat_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

`include "contiguous_page_slot_mapper_macros.svh"

    // Entry table has SLOTS+1 rows, run-length table SLOTS rows.
    localparam int PE_AW = $clog2(SLOTS + 1);
    localparam int RL_AW = $clog2(SLOTS);
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(SLOTS * PAGE_BYTES);
    localparam logic [WALK_W-1:0] SLOTS_WK  = WALK_W'(SLOTS);
    localparam logic [WALK_W:0]   SLOTS_LIM = (WALK_W + 1)'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOTS_SL  = SLOT_W'(SLOTS);
    localparam int VPN_W       = ADDR_W - PAGE_SHIFT;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      clr_cnt_reg;
    logic [SLOT_W-1:0]      fds_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [WALK_W-1:0]      a_reg;      // run start candidate / unmap slot
    logic [WALK_W-1:0]      b_reg;      // walk cursor, then run end
    logic [WALK_W-1:0]      k_reg;      // fill / erase cursor
    logic [WALK_W-1:0]      end_reg;    // erase end
    logic [RUN_W-1:0]       pages_reg;
    logic [PAGE_SHIFT-1:0]  offs_reg;
    logic [ADDR_W-1:0]      page_reg;
    logic [ADDR_W-1:0]      flags_reg;
    out_beat_t              res_reg;
    out_beat_t              out_reg;
    logic                   out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic                   pe_we;
    logic [PE_AW-1:0]       pe_waddr, pe_raddr;
    logic [ADDR_W-1:0]      pe_wdata, pe_q;
    logic                   rl_we;
    logic [RL_AW-1:0]       rl_waddr, rl_raddr;
    logic [RUN_W-1:0]       rl_wdata, rl_q;

    // ------------------------------------------------------------------
    // Decode of the incoming beat
    // ------------------------------------------------------------------
    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   map_zero, map_big, unmap_out, idx_out;
    logic [SIZE_W:0]        span;
    logic [RUN_W-1:0]       pages_in;
    logic [ADDR_W-1:0]      unmap_diff;
    logic [WALK_W-1:0]      unmap_slot;
    logic [WALK_W-1:0]      a_start;
    out_beat_t              res_start;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign map_zero = (in_data.physical_address == '0) || (in_data.map_size == '0);
    assign map_big  = in_data.map_size > MAX_SIZE;
    // Offset plus size, rounded up to whole pages; only the low bits matter
    // once the size has passed the too-large check.
    assign span     = {1'b0, in_data.map_size}
                    + (SIZE_W + 1)'(in_data.physical_address[PAGE_SHIFT-1:0])
                    + (SIZE_W + 1)'(PAGE_BYTES - 1);
    assign pages_in = span[PAGE_SHIFT +: RUN_W];

    assign unmap_diff = in_data.virtual_address - base_reg;
    assign unmap_out  = unmap_diff[ADDR_W-1:PAGE_SHIFT] >= VPN_W'(SLOTS);
    assign unmap_slot = unmap_diff[PAGE_SHIFT +: WALK_W];

    assign idx_out = {1'b0, in_data.entry_index} > (SLOT_W + 1)'(SLOTS);

    // Unmap works on its own slot; map starts the walk at the first dynamic slot.
    assign a_start = (cmd_t'(in_data.command) == CMD_UNMAP)
                   ? unmap_slot : {{(WALK_W - SLOT_W){1'b0}}, fds_reg};

    // Result fields known as the beat arrives; the rest stay zero.
    always_comb
    begin
        res_start = '0;
        case (cmd_t'(in_data.command))
            CMD_MAP:
            begin
                if (map_zero)
                begin
                    res_start.status = STS_ZERO_ARG;
                end
                else if (map_big)
                begin
                    res_start.status = STS_TOO_LARGE;
                end
            end
            CMD_UNMAP:
            begin
                if (unmap_out)
                begin
                    res_start.status = STS_BAD_SLOT;
                end
            end
            default:
            begin
                if (idx_out)
                begin
                    res_start.status = STS_BAD_SLOT;
                end
                else
                begin
                    res_start.first_slot = in_data.entry_index;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Walk, fill and erase steps
    // ------------------------------------------------------------------
    logic [WALK_W:0]        walk_lim;
    logic                   walk_done, walk_fail;
    logic [WALK_W-1:0]      walk_step;
    logic [WALK_W-1:0]      k_inc;
    logic                   fill_last, erase_last;

    assign walk_lim  = {1'b0, a_reg} + {{(WALK_W + 1 - RUN_W){1'b0}}, pages_reg};
    assign walk_done = {1'b0, b_reg} >= walk_lim;
    assign walk_fail = !walk_done && (b_reg >= SLOTS_WK);
    // Skip a whole run at its head, else step one free slot.
    assign walk_step = (rl_q != '0) ? b_reg + WALK_W'(rl_q) : b_reg + WALK_W'(1);

    assign k_inc      = k_reg + WALK_W'(1);
    assign fill_last  = k_inc == b_reg;
    assign erase_last = (k_inc == end_reg) || (k_inc >= SLOTS_WK);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SLOTS_SL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(in_data.command))
                        CMD_MAP:   state_next = (map_zero || map_big) ? ST_RESULT : ST_WALK;
                        CMD_UNMAP: state_next = unmap_out ? ST_RESULT : ST_UNMAP;
                        CMD_WRITE: state_next = ST_RESULT;
                        CMD_READ:  state_next = idx_out ? ST_RESULT : ST_READ;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_FILL;
                end
                else if (walk_fail)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_UNMAP:
            begin
                state_next = (rl_q == '0) ? ST_RESULT : ST_ERASE;
            end
            ST_ERASE:
            begin
                if (erase_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs: handshake and RAM ports
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        pe_we    = 1'b0;
        pe_waddr = k_reg[PE_AW-1:0];
        pe_wdata = '0;
        pe_raddr = in_data.entry_index[PE_AW-1:0];
        rl_we    = 1'b0;
        rl_waddr = a_reg[RL_AW-1:0];
        rl_wdata = '0;
        rl_raddr = walk_step[RL_AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep both tables to zero, one row a cycle.
                pe_we    = 1'b1;
                pe_waddr = clr_cnt_reg[PE_AW-1:0];
                rl_we    = clr_cnt_reg < SLOTS_SL;
                rl_waddr = clr_cnt_reg[RL_AW-1:0];
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                // Launch the first run-length read with the beat itself.
                rl_raddr = (cmd_t'(in_data.command) == CMD_UNMAP)
                         ? unmap_slot[RL_AW-1:0] : fds_reg[RL_AW-1:0];
                if (accept && (cmd_t'(in_data.command) == CMD_WRITE) && !idx_out)
                begin
                    pe_we    = 1'b1;
                    pe_waddr = in_data.entry_index[PE_AW-1:0];
                    pe_wdata = in_data.entry_value;
                end
            end
            ST_WALK:
            begin
                // Record the run at its head once it is found.
                rl_we    = walk_done;
                rl_wdata = pages_reg;
            end
            ST_FILL:
            begin
                pe_we    = 1'b1;
                pe_wdata = page_reg | flags_reg;
            end
            ST_UNMAP:
            begin
                rl_we = 1'b1;
            end
            ST_ERASE:
            begin
                pe_we = 1'b1;
            end
            ST_READ:
            begin
            end
            ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fds_reg       <= '0;
            base_reg      <= DEF_WINDOW_BASE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FIRST_DYNAMIC_SLOT:  fds_reg  <= cfg_data[SLOT_W-1:0];
                    CFG_WINDOW_BASE_ADDRESS: base_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_reg   <= res_start;
                    a_reg     <= a_start;
                    b_reg     <= {{(WALK_W - SLOT_W){1'b0}}, fds_reg};
                    pages_reg <= pages_in;
                    offs_reg  <= in_data.physical_address[PAGE_SHIFT-1:0];
                    page_reg  <= {{(ADDR_W - PHYS_W){1'b0}},
                                  in_data.physical_address[PHYS_W-1:PAGE_SHIFT],
                                  {PAGE_SHIFT{1'b0}}};
                    flags_reg <= in_data.entry_flags;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    res_reg.status         <= STS_OK;
                    res_reg.first_slot     <= a_reg[SLOT_W-1:0];
                    res_reg.slot_count     <= pages_reg[SLOT_W-1:0];
                    res_reg.mapped_address <= base_reg
                        + {{(ADDR_W - SLOT_W - PAGE_SHIFT){1'b0}},
                           a_reg[SLOT_W-1:0], offs_reg};
                    k_reg <= a_reg;
                end
                else if (walk_fail)
                begin
                    res_reg.status <= STS_NO_ROOM;
                end
                else
                begin
                    // A run head moves the candidate start past the run.
                    if (rl_q != '0)
                    begin
                        a_reg <= walk_step;
                    end
                    b_reg <= walk_step;
                end
            end
            ST_FILL:
            begin
                k_reg    <= k_inc;
                page_reg <= page_reg + ADDR_W'(PAGE_BYTES);
            end
            ST_UNMAP:
            begin
                res_reg.first_slot <= a_reg[SLOT_W-1:0];
                res_reg.slot_count <= rl_q[SLOT_W-1:0];
                k_reg              <= a_reg;
                end_reg            <= a_reg + WALK_W'(rl_q);
            end
            ST_ERASE:
            begin
                k_reg <= k_inc;
            end
            ST_READ:
            begin
                res_reg.read_value <= pe_q;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Tables
    // ------------------------------------------------------------------
    cpsm_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (SLOTS + 1)
    ) u_page_entries (
        .clk   (clk),
        .we    (pe_we),
        .waddr (pe_waddr),
        .wdata (pe_wdata),
        .raddr (pe_raddr),
        .rdata (pe_q)
    );

    cpsm_ram #(
        .WIDTH (RUN_W),
        .DEPTH (SLOTS)
    ) u_run_lengths (
        .clk   (clk),
        .we    (rl_we),
        .waddr (rl_waddr),
        .wdata (rl_wdata),
        .raddr (rl_raddr),
        .rdata (rl_q)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CPSM_ASSERT_IMP(a_fill_in_window, state_reg == ST_FILL, k_reg < SLOTS_WK)
    `CPSM_ASSERT_IMP(a_walk_order, state_reg == ST_WALK, b_reg >= a_reg)
    `CPSM_ASSERT_IMP(a_run_fits, (state_reg == ST_WALK) && walk_done, walk_lim <= SLOTS_LIM)
    `CPSM_ASSERT_NXT(a_sweep_complete, state_reg == ST_CLEAR, (state_reg == ST_CLEAR) || ($past(clr_cnt_reg) == SLOTS_SL))

endmodule

`default_nettype wire
